// ===== design/indexed_block_allocator_defines.svh =====
// assertion helpers used by the checker
`ifndef INDEXED_BLOCK_ALLOCATOR_DEFINES_SVH
`define INDEXED_BLOCK_ALLOCATOR_DEFINES_SVH

// clocked property, switched off while reset is high
`define IBA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that is also checked during reset
`define IBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/iba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package iba_pkg;

   // default sizes
   localparam int DEF_DISK_BLOCKS     = 256;
   localparam int DEF_MAX_FILES       = 16;
   localparam int DEF_MAX_FILE_BLOCKS = 16;

   // fixed field widths
   localparam int KIND_W         = 1;
   localparam int FILE_ID_W      = 4;
   localparam int BLOCK_COUNT_W  = 5;
   localparam int STATUS_W       = 3;
   localparam int BLOCK_NUMBER_W = 8;
   localparam int ACTIVE_W       = 9;

   // compare widths wide enough for the parameter ranges
   localparam int COUNT_CMP_W = 7;
   localparam int FILE_CMP_W  = 9;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_CREATE = 1'b0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ID_IN_USE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic                accept;
      logic                clear_step;
      logic                scan_start;
      logic                scan_run;
      logic                del_start;
      logic                del_run;
      logic                dir_del;
      logic                reply_load;
      logic [STATUS_W-1:0] reply_status;
   } iba_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic                clear_done;
      logic                req_delete;
      logic [STATUS_W-1:0] chk_status;
      logic                del_last;
      logic                scan_finish;
      logic                rsp_free;
   } iba_stat_type;

endpackage

`default_nettype wire

// ===== design/iba_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// request channel
interface iba_req_if
   import iba_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic [FILE_ID_W-1:0]     file_id;
   logic [BLOCK_COUNT_W-1:0] block_count;

   modport source (output valid, output kind, output file_id, output block_count,
                   input ready);
   modport sink   (input valid, input kind, input file_id, input block_count,
                   output ready);
endinterface

// result channel
interface iba_rsp_if
   import iba_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic [BLOCK_NUMBER_W-1:0] block_number;
   logic                      last;

   modport source (output valid, output status, output block_number, output last,
                   input ready);
   modport sink   (input valid, input status, input block_number, input last,
                   output ready);
endinterface

`default_nettype wire

// ===== design/iba_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module iba_ctrl
   import iba_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire iba_stat_type stat,
   output iba_cmd_type       cmd
);

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_CHECK    = 3'd2;
   localparam logic [2:0] S_SCAN     = 3'd3;
   localparam logic [2:0] S_DEL      = 3'd4;
   localparam logic [2:0] S_DEL_DONE = 3'd5;
   localparam logic [2:0] S_REPLY    = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [STATUS_W-1:0] code_ff, code_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      cmd.reply_status = code_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            code_in = stat.chk_status;
            if (stat.chk_status != ST_OK) begin
               state_in = S_REPLY;
            end else if (stat.req_delete) begin
               cmd.del_start = 1'b1;
               state_in      = S_DEL;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_finish) begin
               state_in = S_IDLE;
            end
         end
         S_DEL: begin
            cmd.del_run = 1'b1;
            if (stat.del_last) begin
               state_in = S_DEL_DONE;
            end
         end
         S_DEL_DONE: begin
            cmd.dir_del = 1'b1;
            code_in     = ST_OK;
            state_in    = S_REPLY;
         end
         S_REPLY: begin
            if (stat.rsp_free) begin
               cmd.reply_load = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      // a register write restarts the clearing pass
      if (csr_we) begin
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
      code_ff <= code_in;
   end

endmodule

`default_nettype wire

// ===== design/iba_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module iba_datapath
   import iba_pkg::*;
#(
   parameter int DISK_BLOCKS     = DEF_DISK_BLOCKS,
   parameter int MAX_FILES       = DEF_MAX_FILES,
   parameter int MAX_FILE_BLOCKS = DEF_MAX_FILE_BLOCKS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [ACTIVE_W-1:0]       csr_wdata,
   input  wire logic [KIND_W-1:0]         req_kind,
   input  wire logic [FILE_ID_W-1:0]      req_file_id,
   input  wire logic [BLOCK_COUNT_W-1:0]  req_block_count,
   input  wire iba_cmd_type               cmd,
   output iba_stat_type                   stat,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic [BLOCK_NUMBER_W-1:0]      rsp_block_number,
   output logic                           rsp_last
);

   localparam int BLK_W     = $clog2(DISK_BLOCKS);
   localparam int FREE_W    = $clog2(DISK_BLOCKS + 1);
   localparam int FILE_W    = $clog2(MAX_FILES);
   localparam int CNT_W     = $clog2(MAX_FILE_BLOCKS + 1);
   localparam int IDX_DEPTH = MAX_FILES * MAX_FILE_BLOCKS;
   localparam int IDX_AW    = $clog2(IDX_DEPTH);
   localparam int ACT_CMP_W = (FREE_W > ACTIVE_W) ? FREE_W : ACTIVE_W;
   localparam int FC_W      = (FREE_W > COUNT_CMP_W) ? FREE_W : COUNT_CMP_W;
   localparam int BLK_EXT_W = (BLK_W > BLOCK_NUMBER_W) ? BLK_W : BLOCK_NUMBER_W;
   localparam int ACT_RESET = (DISK_BLOCKS < 256) ? DISK_BLOCKS : 256;

   // latched request
   logic [KIND_W-1:0]        req_kind_ff;
   logic [FILE_ID_W-1:0]     req_id_ff;
   logic [BLOCK_COUNT_W-1:0] req_count_ff;

   // directory
   logic             valid_ff [MAX_FILES];
   logic [CNT_W-1:0] len_ff   [MAX_FILES];
   logic [FREE_W-1:0] free_total_ff;

   // memories
   logic             map_mem [DISK_BLOCKS];
   logic [BLK_W-1:0] idx_mem [IDX_DEPTH];
   logic             map_rdata_ff;
   logic [BLK_W-1:0] idx_rdata_ff;
   logic             idx_live_ff;

   // counters
   logic [BLK_W-1:0] clr_addr_ff;
   logic [BLK_W-1:0] rd_addr_ff;
   logic [CNT_W-1:0] taken_ff;
   logic [CNT_W-1:0] del_k_ff;

   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [BLOCK_NUMBER_W-1:0] rsp_block_ff;
   logic                      rsp_last_ff;

   logic [FILE_CMP_W-1:0]  id_wide;
   logic                   id_ok;
   logic [FILE_W-1:0]      id_sel;
   logic                   sel_valid;
   logic [CNT_W-1:0]       sel_len;
   logic [COUNT_CMP_W-1:0] count_cmp;
   logic                   bad_count;
   logic                   no_space;
   logic [STATUS_W-1:0]    chk_status;
   logic [IDX_AW-1:0]      slot_base;
   logic                   rsp_free;
   logic                   free_hit;
   logic                   emit;
   logic                   stall;
   logic                   finish;
   logic [BLK_W-1:0]       map_raddr;
   logic                   map_we;
   logic [BLK_W-1:0]       map_waddr;
   logic                   map_wdata;
   logic [IDX_AW-1:0]      idx_waddr;
   logic [IDX_AW-1:0]      idx_raddr;
   logic [BLK_EXT_W-1:0]   blk_ext;
   logic [ACT_CMP_W-1:0]   wdata_cmp;
   logic [FREE_W-1:0]      active_sat;

   // request checks
   assign id_wide   = FILE_CMP_W'(req_id_ff);
   assign id_ok     = id_wide < FILE_CMP_W'(MAX_FILES);
   assign id_sel    = id_wide[FILE_W-1:0];
   assign sel_valid = id_ok && valid_ff[id_sel];
   assign sel_len   = len_ff[id_sel];
   assign count_cmp = COUNT_CMP_W'(req_count_ff);
   assign bad_count = (count_cmp == '0) || (count_cmp > COUNT_CMP_W'(MAX_FILE_BLOCKS));
   assign no_space  = FC_W'(free_total_ff) < FC_W'(req_count_ff);

   always_comb begin
      if (req_kind_ff == KIND_DELETE) begin
         chk_status = sel_valid ? ST_OK : ST_NOT_FOUND;
      end else if (bad_count) begin
         chk_status = ST_BAD_COUNT;
      end else if (sel_valid || !id_ok) begin
         chk_status = ST_ID_IN_USE;
      end else if (no_space) begin
         chk_status = ST_NO_SPACE;
      end else begin
         chk_status = ST_OK;
      end
   end

   assign slot_base = IDX_AW'(id_sel) * IDX_AW'(MAX_FILE_BLOCKS);

   // first-fit scan, one bitmap cell per cycle unless the result side stalls
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign free_hit = cmd.scan_run && !map_rdata_ff;
   assign emit     = free_hit && rsp_free;
   assign stall    = free_hit && !rsp_free;
   assign finish   = emit && ((COUNT_CMP_W'(taken_ff) + COUNT_CMP_W'(1)) == count_cmp);

   always_comb begin
      if (cmd.scan_start) begin
         map_raddr = '0;
      end else if (stall) begin
         map_raddr = rd_addr_ff;
      end else begin
         map_raddr = rd_addr_ff + BLK_W'(1);
      end
   end

   // bitmap write port
   always_comb begin
      map_we    = 1'b0;
      map_waddr = clr_addr_ff;
      map_wdata = 1'b0;
      if (cmd.clear_step) begin
         map_we = 1'b1;
      end else if (emit) begin
         map_we    = 1'b1;
         map_waddr = rd_addr_ff;
         map_wdata = 1'b1;
      end else if (idx_live_ff) begin
         map_we    = 1'b1;
         map_waddr = idx_rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rdata_ff <= map_mem[map_raddr];
   end

   assign idx_waddr = slot_base + IDX_AW'(taken_ff);
   assign idx_raddr = slot_base + IDX_AW'(del_k_ff);

   always_ff @(posedge clock) begin
      if (emit) begin
         idx_mem[idx_waddr] <= rd_addr_ff;
      end
      idx_rdata_ff <= idx_mem[idx_raddr];
   end

   assign wdata_cmp  = ACT_CMP_W'(csr_wdata);
   assign active_sat = (wdata_cmp > ACT_CMP_W'(DISK_BLOCKS)) ? FREE_W'(DISK_BLOCKS)
                                                             : FREE_W'(wdata_cmp);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_kind_ff  <= req_kind;
         req_id_ff    <= req_file_id;
         req_count_ff <= req_block_count;
      end
      rd_addr_ff <= map_raddr;
      if (cmd.scan_start) begin
         taken_ff <= '0;
      end else if (emit) begin
         taken_ff <= taken_ff + CNT_W'(1);
      end
      if (cmd.del_start) begin
         del_k_ff <= '0;
      end else if (cmd.del_run) begin
         del_k_ff <= del_k_ff + CNT_W'(1);
      end
   end

   // directory, free count, clear pointer
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         for (int f = 0; f < MAX_FILES; f++) begin
            valid_ff[f] <= 1'b0;
            len_ff[f]   <= '0;
         end
         free_total_ff <= reset ? FREE_W'(ACT_RESET) : active_sat;
         clr_addr_ff   <= '0;
         idx_live_ff   <= 1'b0;
      end else begin
         idx_live_ff <= cmd.del_run;
         if (cmd.clear_step) begin
            clr_addr_ff <= clr_addr_ff + BLK_W'(1);
         end
         if (finish) begin
            valid_ff[id_sel] <= 1'b1;
            len_ff[id_sel]   <= CNT_W'(req_count_ff);
            free_total_ff    <= free_total_ff - FREE_W'(req_count_ff);
         end else if (cmd.dir_del) begin
            valid_ff[id_sel] <= 1'b0;
            len_ff[id_sel]   <= '0;
            free_total_ff    <= free_total_ff + FREE_W'(sel_len);
         end
      end
   end

   // output register
   assign blk_ext = BLK_EXT_W'(rd_addr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.reply_load || emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.reply_load) begin
         rsp_status_ff <= cmd.reply_status;
         rsp_block_ff  <= '0;
         rsp_last_ff   <= 1'b1;
      end else if (emit) begin
         rsp_status_ff <= ST_OK;
         rsp_block_ff  <= blk_ext[BLOCK_NUMBER_W-1:0];
         rsp_last_ff   <= finish;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_block_number = rsp_block_ff;
   assign rsp_last         = rsp_last_ff;

   assign stat.clear_done  = (clr_addr_ff == BLK_W'(DISK_BLOCKS - 1));
   assign stat.req_delete  = (req_kind_ff == KIND_DELETE);
   assign stat.chk_status  = chk_status;
   assign stat.del_last    = (del_k_ff == (sel_len - CNT_W'(1)));
   assign stat.scan_finish = finish;
   assign stat.rsp_free    = rsp_free;

endmodule

`default_nettype wire

// ===== design/indexed_block_allocator.sv =====
// Indexed block allocator: a used/free bitmap over the managed disk blocks plus a
// directory of files by numeric id, each with an index list of its blocks. A create
// beat gets one result beat per allocated block (lowest free blocks first, last set
// on the final one) or a single error beat; a delete gets one beat. One request is
// worked at a time. A create scans the bitmap one block per cycle from block zero,
// pausing while the result side stalls; a delete reads its index list one block per
// cycle. After reset and after every write of active_blocks a clearing pass empties
// the bitmap, during which no request is taken. Writing active_blocks also empties
// the directory.
`timescale 1ns / 1ps
`default_nettype none

module indexed_block_allocator
   import iba_pkg::*;
#(
   parameter int DISK_BLOCKS     = DEF_DISK_BLOCKS,
   parameter int MAX_FILES       = DEF_MAX_FILES,
   parameter int MAX_FILE_BLOCKS = DEF_MAX_FILE_BLOCKS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   iba_req_if.sink                  req_bus,
   iba_rsp_if.source                rsp_bus,
   input  wire logic                csr_we,
   input  wire logic [ACTIVE_W-1:0] csr_wdata
);

   // command and status between the sequencer and the datapath
   iba_cmd_type  cmd;
   iba_stat_type stat;

   // sequencer: clearing pass, request checks, scan and delete steps
   iba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // bitmap, index lists, directory and the result register
   iba_datapath #(
      .DISK_BLOCKS     (DISK_BLOCKS),
      .MAX_FILES       (MAX_FILES),
      .MAX_FILE_BLOCKS (MAX_FILE_BLOCKS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_kind         (req_bus.kind),
      .req_file_id      (req_bus.file_id),
      .req_block_count  (req_bus.block_count),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_status       (rsp_bus.status),
      .rsp_block_number (rsp_bus.block_number),
      .rsp_last         (rsp_bus.last)
   );

endmodule

`default_nettype wire

// ===== design/iba_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_block_allocator_defines.svh"

module iba_checker
   import iba_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      csr_we,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic [STATUS_W-1:0]       rsp_status,
   input wire logic [BLOCK_NUMBER_W-1:0] rsp_block_number,
   input wire logic                      rsp_last
);

   // a stalled result beat holds
   `IBA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_block_number) && $stable(rsp_last), "result beat changed while stalled")

   // an error beat is a lone final beat with no block
   `IBA_ASSERT(a_err_shape, clock, reset, rsp_valid && (rsp_status != ST_OK) |-> rsp_last && (rsp_block_number == '0), "error beat not last or carries a block")

   // one request at a time
   `IBA_ASSERT(a_one_req, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while one is in work")

   // reset and register writes start a clearing pass
   `IBA_ASSERT_ALWAYS(a_clear_pass, clock, reset || csr_we |=> !req_ready, "request side open during clearing pass")

endmodule

bind indexed_block_allocator iba_checker u_iba_checker (
   .clock            (clock),
   .reset            (reset),
   .csr_we           (csr_we),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_block_number (rsp_bus.block_number),
   .rsp_last         (rsp_bus.last)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import iba_pkg::*;

   // run shape
   localparam int LIMIT_CYCLES  = 1_500_000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 45;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE        = 12;
   localparam int SHOWN_FAULTS  = 10;

   typedef enum logic {ROW_REQ, ROW_CFG} row_op_type;

   // one result beat as the block presents it
   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [BLOCK_NUMBER_W-1:0] block;
      logic                      last;
   } beat_type;

   // one line of the directed table
   typedef struct {
      row_op_type               op;
      logic [KIND_W-1:0]        kind;
      logic [FILE_ID_W-1:0]     file_id;
      logic [BLOCK_COUNT_W-1:0] count;
      logic [ACTIVE_W-1:0]      csr_val;
      bit                       typed;
      beat_type                 want;
   } row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic [ACTIVE_W-1:0] csr_wdata = '0;

   iba_req_if req_ch();
   iba_rsp_if rsp_ch();

   indexed_block_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow copy of the allocator store
   logic [ACTIVE_W-1:0]       managed_blocks;
   bit                        used_map [DEF_DISK_BLOCKS];
   int unsigned               free_left;
   bit                        slot_used [DEF_MAX_FILES];
   int unsigned               slot_len [DEF_MAX_FILES];
   logic [BLOCK_NUMBER_W-1:0] slot_blocks [DEF_MAX_FILES][DEF_MAX_FILE_BLOCKS];

   beat_type fresh_beats [$];   // beats caused by the request just taken
   beat_type owed_beats [$];    // beats the block still has to deliver
   row_type  directed_rows [$];

   // knobs the stimulus side sets for the two sides
   bit calm          = 1'b0;
   bit long_hold_go  = 1'b0;
   int send_idle_pct = 25;
   int take_stall_pct = 25;

   // tallies
   int fault_count = 0;
   int sent_count  = 0;
   int beat_count  = 0;
   int csr_count   = 0;
   int seen_status [8];

   function automatic beat_type mk_beat(logic [STATUS_W-1:0] status,
                                        logic [BLOCK_NUMBER_W-1:0] block, logic last);
      beat_type b;
      b.status = status;
      b.block  = block;
      b.last   = last;
      return b;
   endfunction

   // register write empties the whole store
   function automatic void set_managed(logic [ACTIVE_W-1:0] value);
      managed_blocks = (value > DEF_DISK_BLOCKS) ? ACTIVE_W'(DEF_DISK_BLOCKS) : value;
      foreach (used_map[i]) used_map[i] = 1'b0;
      foreach (slot_used[i]) begin
         slot_used[i] = 1'b0;
         slot_len[i]  = 0;
      end
      free_left = managed_blocks;
   endfunction

   // first-fit create or delete, fills fresh_beats
   function automatic void plan_allocation(logic [KIND_W-1:0] kind,
                                           logic [FILE_ID_W-1:0] fid,
                                           logic [BLOCK_COUNT_W-1:0] count);
      int unsigned taken;
      int unsigned i;
      logic [BLOCK_NUMBER_W-1:0] b;
      fresh_beats.delete();
      if (kind == KIND_CREATE) begin
         // bad count wins over id in use, which wins over no space
         if (count == 0 || count > DEF_MAX_FILE_BLOCKS) begin
            fresh_beats.push_back(mk_beat(ST_BAD_COUNT, '0, 1'b1));
         end else if (slot_used[fid]) begin
            fresh_beats.push_back(mk_beat(ST_ID_IN_USE, '0, 1'b1));
         end else if (free_left < count) begin
            fresh_beats.push_back(mk_beat(ST_NO_SPACE, '0, 1'b1));
         end else begin
            taken = 0;
            for (i = 0; i < managed_blocks && i < DEF_DISK_BLOCKS && taken < count; i++) begin
               if (!used_map[i]) begin
                  used_map[i] = 1'b1;
                  slot_blocks[fid][taken] = BLOCK_NUMBER_W'(i);
                  fresh_beats.push_back(mk_beat(ST_OK, BLOCK_NUMBER_W'(i), taken + 1 == count));
                  taken++;
               end
            end
            free_left      -= taken;
            slot_used[fid] = 1'b1;
            slot_len[fid]  = taken;
         end
      end else begin
         if (!slot_used[fid]) begin
            fresh_beats.push_back(mk_beat(ST_NOT_FOUND, '0, 1'b1));
         end else begin
            for (i = 0; i < slot_len[fid]; i++) begin
               b = slot_blocks[fid][i];
               if (used_map[b]) begin
                  used_map[b] = 1'b0;
                  free_left++;
               end
            end
            slot_used[fid] = 1'b0;
            slot_len[fid]  = 0;
            fresh_beats.push_back(mk_beat(ST_OK, '0, 1'b1));
         end
      end
   endfunction

   // directed table builders
   task automatic req_row(logic [KIND_W-1:0] kind, logic [FILE_ID_W-1:0] fid,
                          logic [BLOCK_COUNT_W-1:0] count);
      row_type r;
      r.op = ROW_REQ; r.kind = kind; r.file_id = fid; r.count = count;
      r.csr_val = '0; r.typed = 1'b0; r.want = '0;
      directed_rows.push_back(r);
   endtask

   task automatic req_known(logic [KIND_W-1:0] kind, logic [FILE_ID_W-1:0] fid,
                            logic [BLOCK_COUNT_W-1:0] count, logic [STATUS_W-1:0] status,
                            logic [BLOCK_NUMBER_W-1:0] block, logic last);
      row_type r;
      r.op = ROW_REQ; r.kind = kind; r.file_id = fid; r.count = count;
      r.csr_val = '0; r.typed = 1'b1; r.want = mk_beat(status, block, last);
      directed_rows.push_back(r);
   endtask

   task automatic cfg_row(logic [ACTIVE_W-1:0] value);
      row_type r;
      r.op = ROW_CFG; r.kind = KIND_CREATE; r.file_id = '0; r.count = '0;
      r.csr_val = value; r.typed = 1'b0; r.want = '0;
      directed_rows.push_back(r);
   endtask

   // offer one request beat, hold it until taken, then book its results
   task automatic send_request(logic [KIND_W-1:0] kind, logic [FILE_ID_W-1:0] fid,
                               logic [BLOCK_COUNT_W-1:0] count, bit typed, beat_type want);
      if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= kind;
      req_ch.file_id     <= fid;
      req_ch.block_count <= count;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      plan_allocation(kind, fid, count);
      if (typed) owed_beats.push_back(want);
      else foreach (fresh_beats[i]) owed_beats.push_back(fresh_beats[i]);
      sent_count++;
   endtask

   // stop offering and let every owed beat come back
   task automatic drain_beats();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (owed_beats.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // register writes only ever land on an idle block
   task automatic write_csr(logic [ACTIVE_W-1:0] value);
      drain_beats();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      set_managed(value);
      csr_count++;
   endtask

   // mostly well-formed creates and deletes, some raw noise
   task automatic random_request();
      int r;
      int pool [$];
      logic [KIND_W-1:0]        kind;
      logic [FILE_ID_W-1:0]     fid;
      logic [BLOCK_COUNT_W-1:0] count;
      r = $urandom_range(0, 99);
      fid = FILE_ID_W'($urandom_range(0, DEF_MAX_FILES - 1));
      if (r < 50) begin
         kind = KIND_CREATE;
         foreach (slot_used[i]) if (!slot_used[i]) pool.push_back(i);
         if (pool.size() != 0) fid = FILE_ID_W'(pool[$urandom_range(0, pool.size() - 1)]);
         // mostly short files keep the scans short
         count = ($urandom_range(0, 3) == 0) ? BLOCK_COUNT_W'($urandom_range(1, 16))
                                             : BLOCK_COUNT_W'($urandom_range(1, 6));
      end else if (r < 82) begin
         kind = KIND_DELETE;
         foreach (slot_used[i]) if (slot_used[i]) pool.push_back(i);
         if (pool.size() != 0) fid = FILE_ID_W'(pool[$urandom_range(0, pool.size() - 1)]);
         count = BLOCK_COUNT_W'($urandom_range(0, 31));
      end else begin
         kind  = KIND_W'($urandom_range(0, 1));
         count = BLOCK_COUNT_W'($urandom_range(0, 31));
      end
      send_request(kind, fid, count, 1'b0, '0);
   endtask

   task automatic note_fault(string what, beat_type want, beat_type got);
      fault_count++;
      if (fault_count <= SHOWN_FAULTS)
         $display("%0t %s: want status %0d block %0d last %0d, got status %0d block %0d last %0d",
                  $realtime, what, want.status, want.block, want.last,
                  got.status, got.block, got.last);
   endtask

   // stimulus side
   initial begin : stimulus
      logic [ACTIVE_W-1:0] phase_csr;
      req_ch.valid       <= 1'b0;
      req_ch.kind        <= KIND_CREATE;
      req_ch.file_id     <= '0;
      req_ch.block_count <= '0;
      set_managed(ACTIVE_W'(DEF_DISK_BLOCKS));

      // errors and the first block straight after reset
      req_known(KIND_CREATE, 4'd0,  5'd0,  ST_BAD_COUNT, 8'd0, 1'b1);
      req_known(KIND_CREATE, 4'd0,  5'd17, ST_BAD_COUNT, 8'd0, 1'b1);
      req_known(KIND_CREATE, 4'd15, 5'd31, ST_BAD_COUNT, 8'd0, 1'b1);
      req_known(KIND_DELETE, 4'd5,  5'd0,  ST_NOT_FOUND, 8'd0, 1'b1);
      req_known(KIND_CREATE, 4'd0,  5'd1,  ST_OK,        8'd0, 1'b1);
      req_known(KIND_CREATE, 4'd0,  5'd3,  ST_ID_IN_USE, 8'd0, 1'b1);
      req_row  (KIND_CREATE, 4'd15, 5'd16);
      req_row  (KIND_CREATE, 4'd7,  5'd16);
      req_known(KIND_DELETE, 4'd0,  5'd0,  ST_OK,        8'd0, 1'b1);
      // hole at block zero gets reused first
      req_row  (KIND_CREATE, 4'd1,  5'd2);
      // delete ignores the count field
      req_known(KIND_DELETE, 4'd15, 5'd31, ST_OK,        8'd0, 1'b1);
      req_known(KIND_DELETE, 4'd15, 5'd0,  ST_NOT_FOUND, 8'd0, 1'b1);
      // bad count is checked before id in use
      req_known(KIND_CREATE, 4'd1,  5'd0,  ST_BAD_COUNT, 8'd0, 1'b1);
      req_row  (KIND_CREATE, 4'd9,  5'd16);
      // single managed block
      cfg_row(9'd1);
      req_known(KIND_CREATE, 4'd2,  5'd1,  ST_OK,        8'd0, 1'b1);
      req_known(KIND_CREATE, 4'd3,  5'd1,  ST_NO_SPACE,  8'd0, 1'b1);
      // id in use is checked before no space
      req_known(KIND_CREATE, 4'd2,  5'd1,  ST_ID_IN_USE, 8'd0, 1'b1);
      req_known(KIND_DELETE, 4'd2,  5'd0,  ST_OK,        8'd0, 1'b1);
      // no managed blocks at all
      cfg_row(9'd0);
      req_known(KIND_CREATE, 4'd0,  5'd1,  ST_NO_SPACE,  8'd0, 1'b1);
      req_known(KIND_CREATE, 4'd0,  5'd16, ST_NO_SPACE,  8'd0, 1'b1);
      // the register write emptied the directory
      req_known(KIND_DELETE, 4'd7,  5'd0,  ST_NOT_FOUND, 8'd0, 1'b1);
      // out of range value saturates to the full disk
      cfg_row(9'd511);
      req_row  (KIND_CREATE, 4'd4,  5'd16);
      req_row  (KIND_CREATE, 4'd10, 5'd16);
      req_known(KIND_DELETE, 4'd4,  5'd0,  ST_OK,        8'd0, 1'b1);
      req_row  (KIND_CREATE, 4'd12, 5'd8);

      // reset held, then released
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].op == ROW_CFG) write_csr(directed_rows[i].csr_val);
         else send_request(directed_rows[i].kind, directed_rows[i].file_id,
                           directed_rows[i].count, directed_rows[i].typed,
                           directed_rows[i].want);
      end

      // random phases, each under its own register setting
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: phase_csr = 9'd256;
            1: phase_csr = 9'd511;
            2: phase_csr = 9'd40;
            3: phase_csr = 9'd1;
            4: phase_csr = 9'd0;
            5: phase_csr = ACTIVE_W'($urandom_range(1, 256));
            6: phase_csr = 9'd17;
            7: phase_csr = ACTIVE_W'($urandom_range(257, 511));
            8: phase_csr = ACTIVE_W'($urandom_range(1, 256));
            default: phase_csr = 9'd256;
         endcase
         write_csr(phase_csr);
         send_idle_pct  = (p % 3) * 25;
         take_stall_pct = ((p + 1) % 3) * 25;
         // last phase runs flat out
         if (p == RANDOM_PHASES - 1) calm = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver hold-off while requests keep coming
            if (p == 2 && n == 20) long_hold_go <= 1'b1;
            // sender waits for every owed beat mid phase
            if (p == 5 && n == 20) drain_beats();
            random_request();
         end
      end

      drain_beats();
      $display("covered %0d requests, %0d result beats, %0d register writes, sizes 0 to 511",
               sent_count, beat_count, csr_count);
      $display("status mix: ok %0d, no space %0d, bad count %0d, id in use %0d, not found %0d",
               seen_status[ST_OK], seen_status[ST_NO_SPACE], seen_status[ST_BAD_COUNT],
               seen_status[ST_ID_IN_USE], seen_status[ST_NOT_FOUND]);
      if (fault_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // result side: check each taken beat, then pick ready for the next edge
   initial begin : collector
      int       hold_left;
      int       stall_left;
      bit       hold_done;
      beat_type got;
      beat_type want;
      hold_left  = 0;
      stall_left = 0;
      hold_done  = 1'b0;
      foreach (seen_status[i]) seen_status[i] = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got = mk_beat(rsp_ch.status, rsp_ch.block_number, rsp_ch.last);
            beat_count++;
            if (!$isunknown(got.status)) seen_status[got.status]++;
            if (owed_beats.size() == 0) begin
               note_fault("beat with nothing owed", '0, got);
            end else begin
               want = owed_beats.pop_front();
               if (got.status !== want.status || got.block !== want.block ||
                   got.last !== want.last)
                  note_fault("beat mismatch", want, got);
            end
         end
         // long hold-off counted here, starts once when asked
         if (long_hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < take_stall_pct) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d beats still owed", cycle_count,
               owed_beats.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/iba_pkg.sv
design/iba_if.sv
design/iba_ctrl.sv
design/iba_datapath.sv
design/indexed_block_allocator.sv
design/iba_checker.sv
verif/tb.sv
